FILE: design/rsi_pkg.sv
// Shared types and constants for the ray/segment intersection block.
package rsi_pkg;

    localparam int XW = 32;
    localparam int FW = 17;
    localparam int NW = 18;
    localparam int EW = 33;
    localparam int PW = 66;
    localparam int CW = 67;
    localparam int RW = 68;
    localparam int QB = 17;
    localparam int SW = 66;
    localparam int BW = 102;
    localparam int AW = 5;

    localparam logic [FW-1:0] FRAC_ONE = 17'h10000;

    typedef enum logic [2:0] {
        REG_SX  = 3'd0,
        REG_SY  = 3'd1,
        REG_EX  = 3'd2,
        REG_EY  = 3'd3,
        REG_ONE = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic                 busy;
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic [SW-1:0]        ee;
    } t_norm_res;

endpackage

FILE: design/rsi_norm.sv
// Edge normal unit: squared length and unit right normal, one bit per cycle.
module rsi_norm
    import rsi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [EW-1:0] i_ex,
    input  logic signed [EW-1:0] i_ey,
    output t_norm_res            o_res
);

    typedef enum logic [1:0] {ST_IDLE, ST_SQ, ST_SUM, ST_ITER} t_state;

    t_state          r_state;
    logic [4:0]      r_cnt;
    logic [SW-1:0]   r_sqx, r_sqy, r_ee;
    logic [BW-1:0]   r_bk, r_pa, r_pb, r_mka, r_mkb;
    logic [FW-1:0]   r_ma, r_mb;
    logic            r_neg_a, r_neg_b;

    logic signed [PW-1:0] sq_x, sq_y;
    logic [SW-1:0]   ee_sum;
    logic [BW-1:0]   test_a, test_b, tgt_a, tgt_b;
    logic            acc_a, acc_b;

    assign sq_x   = i_ex * i_ex;
    assign sq_y   = i_ey * i_ey;
    assign ee_sum = r_sqx + r_sqy;
    // a: normal x from ey, target ey^2 << 32; b: normal y from -ex
    assign tgt_a  = {{(BW-SW-32){1'b0}}, r_sqy, 32'b0};
    assign tgt_b  = {{(BW-SW-32){1'b0}}, r_sqx, 32'b0};
    assign test_a = r_pa + r_mka + r_bk;
    assign test_b = r_pb + r_mkb + r_bk;
    assign acc_a  = test_a <= tgt_a;
    assign acc_b  = test_b <= tgt_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SQ;
            r_cnt   <= '0;
        end else if (i_start) begin
            r_state <= ST_SQ;
        end else begin
            case (r_state)
                ST_IDLE: begin
                end
                ST_SQ: begin
                    r_sqx   <= sq_x[SW-1:0];
                    r_sqy   <= sq_y[SW-1:0];
                    r_neg_a <= i_ey[EW-1];
                    r_neg_b <= !i_ex[EW-1] && (i_ex != '0);
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_ee    <= ee_sum;
                    r_bk    <= {{(BW-SW-32){1'b0}}, ee_sum, 32'b0};
                    r_pa    <= '0;
                    r_pb    <= '0;
                    r_mka   <= '0;
                    r_mkb   <= '0;
                    r_ma    <= '0;
                    r_mb    <= '0;
                    r_cnt   <= 5'(QB - 1);
                    r_state <= ST_ITER;
                end
                ST_ITER: begin
                    if (acc_a) begin
                        r_pa  <= test_a;
                        r_mka <= (r_mka + {r_bk[BW-2:0], 1'b0}) >> 1;
                    end else begin
                        r_mka <= r_mka >> 1;
                    end
                    if (acc_b) begin
                        r_pb  <= test_b;
                        r_mkb <= (r_mkb + {r_bk[BW-2:0], 1'b0}) >> 1;
                    end else begin
                        r_mkb <= r_mkb >> 1;
                    end
                    r_bk <= r_bk >> 2;
                    r_ma <= {r_ma[FW-2:0], acc_a};
                    r_mb <= {r_mb[FW-2:0], acc_b};
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == '0) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_res.busy = (r_state != ST_IDLE);
    assign o_res.nx   = r_neg_a ? -$signed({1'b0, r_ma}) : $signed({1'b0, r_ma});
    assign o_res.ny   = r_neg_b ? -$signed({1'b0, r_mb}) : $signed({1'b0, r_mb});
    assign o_res.ee   = r_ee;

endmodule

FILE: design/ray_segment_intersection_top.sv
// Pipeline: input capture, products, cross terms, sign fix, 17 restoring
// divide stages, fraction check, hit point, segment projection, output
// register; one global stall. Throughput is one item per cycle while o_stall
// is low, set by the one-bit-per-stage divider.
// Reset is synchronous; after reset and after each endpoint write the normal
// unit runs its square, sum and iteration states, holding input stall high.
module ray_segment_intersection_top
    import rsi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AW-1:0]        paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [XW-1:0] i_origin_x,
    input  logic signed [XW-1:0] i_origin_y,
    input  logic signed [XW-1:0] i_delta_x,
    input  logic signed [XW-1:0] i_delta_y,
    input  logic [FW-1:0]        i_max_fraction,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_hit,
    output logic [FW-1:0]        o_fraction,
    output logic signed [XW-1:0] o_point_x,
    output logic signed [XW-1:0] o_point_y,
    output logic signed [NW-1:0] o_normal_x,
    output logic signed [NW-1:0] o_normal_y
);

    typedef struct packed {
        logic signed [XW-1:0] ox;
        logic signed [XW-1:0] oy;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic [FW-1:0]        mf;
        logic                 numpos;
        logic                 miss;
    } t_side;

    // configuration
    logic signed [XW-1:0] r_sx, r_sy, r_endx, r_endy;
    logic                 r_one;
    logic                 cfg_wr, edge_wr;
    t_norm_res            w_norm;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign edge_wr = cfg_wr && (paddr[4:2] == REG_SX || paddr[4:2] == REG_SY ||
                                paddr[4:2] == REG_EX || paddr[4:2] == REG_EY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx   <= '0;
            r_sy   <= '0;
            r_endx <= '0;
            r_endy <= '0;
            r_one  <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_SX:  r_sx   <= pwdata;
                REG_SY:  r_sy   <= pwdata;
                REG_EX:  r_endx <= pwdata;
                REG_EY:  r_endy <= pwdata;
                REG_ONE: r_one  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_SX:  prdata = r_sx;
            REG_SY:  prdata = r_sy;
            REG_EX:  prdata = r_endx;
            REG_EY:  prdata = r_endy;
            REG_ONE: prdata = {31'b0, r_one};
            default: prdata = '0;
        endcase
    end

    logic signed [EW-1:0] e_x, e_y;
    logic                 zero_edge;

    assign e_x       = {r_endx[XW-1], r_endx} - {r_sx[XW-1], r_sx};
    assign e_y       = {r_endy[XW-1], r_endy} - {r_sy[XW-1], r_sy};
    assign zero_edge = (e_x == '0) && (e_y == '0);

    rsi_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (edge_wr),
        .i_ex    (e_x),
        .i_ey    (e_y),
        .o_res   (w_norm)
    );

    // handshake
    logic r_ov, en, acc;

    assign en      = !(r_ov && i_stall);
    assign o_stall = !en || w_norm.busy;
    assign acc     = i_valid && !o_stall;

    // S1: input capture, w = start - origin
    logic                 r1_v;
    t_side                r1_s;
    logic signed [EW-1:0] r1_wx, r1_wy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v      <= acc;
            r1_s.ox   <= i_origin_x;
            r1_s.oy   <= i_origin_y;
            r1_s.dx   <= i_delta_x;
            r1_s.dy   <= i_delta_y;
            r1_s.mf   <= (i_max_fraction > FRAC_ONE) ? FRAC_ONE : i_max_fraction;
            r1_s.numpos <= 1'b0;
            r1_s.miss <= 1'b0;
            r1_wx <= {r_sx[XW-1], r_sx} - {i_origin_x[XW-1], i_origin_x};
            r1_wy <= {r_sy[XW-1], r_sy} - {i_origin_y[XW-1], i_origin_y};
        end
    end

    // S2: cross products
    logic                 r2_v;
    t_side                r2_s;
    logic signed [PW-1:0] r2_pa, r2_pb, r2_pc, r2_pd;
    logic signed [EW-1:0] dx_e, dy_e;

    assign dx_e = {r1_s.dx[XW-1], r1_s.dx};
    assign dy_e = {r1_s.dy[XW-1], r1_s.dy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v  <= r1_v;
            r2_s  <= r1_s;
            r2_pa <= e_y * r1_wx;
            r2_pb <= e_x * r1_wy;
            r2_pc <= e_y * dx_e;
            r2_pd <= e_x * dy_e;
        end
    end

    // S3: numerator and denominator
    logic                 r3_v;
    t_side                r3_s;
    logic signed [CW-1:0] r3_num, r3_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v   <= r2_v;
            r3_s   <= r2_s;
            r3_num <= {r2_pa[PW-1], r2_pa} - {r2_pb[PW-1], r2_pb};
            r3_den <= {r2_pc[PW-1], r2_pc} - {r2_pd[PW-1], r2_pd};
        end
    end

    // S4 (divider index 0): make the denominator positive
    logic [QB:0]   r_dv;
    logic [RW-1:0] r_dr [QB+1];
    logic [CW-1:0] r_dd [QB+1];
    logic [FW-1:0] r_q  [QB+1];
    t_side         r_ds [QB+1];

    logic [CW-1:0] nn4, dd4;
    logic          numpos4, miss4;
    t_side         s4;

    assign nn4     = r3_den[CW-1] ? CW'(-r3_num) : r3_num;
    assign dd4     = r3_den[CW-1] ? CW'(-r3_den) : r3_den;
    assign numpos4 = !r3_num[CW-1] && (r3_num != '0);
    assign miss4   = zero_edge || (r_one && numpos4) || (r3_den == '0) || nn4[CW-1];

    always_comb begin
        s4        = r3_s;
        s4.numpos = numpos4;
        s4.miss   = miss4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r3_v;
            r_dr[0] <= {1'b0, nn4};
            r_dd[0] <= dd4;
            r_q[0]  <= '0;
            r_ds[0] <= s4;
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar j = 1; j <= QB; j++) begin : g_div
        logic          ge;
        logic [RW-1:0] rs;
        t_side         sn;

        assign ge = r_dr[j-1] >= {1'b0, r_dd[j-1]};
        assign rs = ge ? r_dr[j-1] - {1'b0, r_dd[j-1]} : r_dr[j-1];

        if (j == 1) begin : g_ovf
            always_comb begin
                sn      = r_ds[j-1];
                sn.miss = r_ds[j-1].miss || (r_dr[j-1] >= {r_dd[j-1], 1'b0});
            end
        end else begin : g_pass
            assign sn = r_ds[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j] <= 1'b0;
            end else if (en) begin
                r_dv[j] <= r_dv[j-1];
                r_dr[j] <= {rs[RW-2:0], 1'b0};
                r_dd[j] <= r_dd[j-1];
                r_q[j]  <= {r_q[j-1][FW-2:0], ge};
                r_ds[j] <= sn;
            end
        end
    end

    // S6: fraction check and q * delta
    logic                 r6_v, r6_miss, r6_numpos;
    logic [FW-1:0]        r6_q;
    logic signed [XW-1:0] r6_ox, r6_oy;
    logic signed [49:0]   r6_mx, r6_my;
    logic signed [FW:0]   q_s;

    assign q_s = $signed({1'b0, r_q[QB]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v      <= r_dv[QB];
            // exact t <= max_fraction: equal quotient with a remainder is above it
            r6_miss   <= r_ds[QB].miss || (r_q[QB] > r_ds[QB].mf) ||
                         ((r_q[QB] == r_ds[QB].mf) && (r_dr[QB] != '0));
            r6_numpos <= r_ds[QB].numpos;
            r6_q      <= r_q[QB];
            r6_ox     <= r_ds[QB].ox;
            r6_oy     <= r_ds[QB].oy;
            r6_mx     <= q_s * r_ds[QB].dx;
            r6_my     <= q_s * r_ds[QB].dy;
        end
    end

    // S7: hit point, floor of q * delta / 1.0
    logic              r7_v, r7_miss, r7_numpos;
    logic [FW-1:0]     r7_q;
    logic signed [33:0] r7_px, r7_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v      <= r6_v;
            r7_miss   <= r6_miss;
            r7_numpos <= r6_numpos;
            r7_q      <= r6_q;
            r7_px     <= {{2{r6_ox[XW-1]}}, r6_ox} + r6_mx[49:16];
            r7_py     <= {{2{r6_oy[XW-1]}}, r6_oy} + r6_my[49:16];
        end
    end

    // S8: projection terms on the edge
    logic               r8_v, r8_miss, r8_numpos;
    logic [FW-1:0]      r8_q;
    logic signed [33:0] r8_px, r8_py;
    logic signed [67:0] r8_ta, r8_tb;
    logic signed [34:0] ux, uy;

    assign ux = {r7_px[33], r7_px} - {{3{r_sx[XW-1]}}, r_sx};
    assign uy = {r7_py[33], r7_py} - {{3{r_sy[XW-1]}}, r_sy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (en) begin
            r8_v      <= r7_v;
            r8_miss   <= r7_miss;
            r8_numpos <= r7_numpos;
            r8_q      <= r7_q;
            r8_px     <= r7_px;
            r8_py     <= r7_py;
            r8_ta     <= ux * e_x;
            r8_tb     <= uy * e_y;
        end
    end

    // S9: segment test, saturation, output register
    logic [68:0]          s9;
    logic                 hit9;
    logic signed [XW-1:0] satx, saty;
    logic signed [NW-1:0] nx9, ny9;

    assign s9   = {r8_ta[67], r8_ta} + {r8_tb[67], r8_tb};
    assign hit9 = !r8_miss && !s9[68] && (s9[67:0] <= {2'b0, w_norm.ee});
    assign satx = (r8_px[33:31] == 3'b000 || r8_px[33:31] == 3'b111) ? r8_px[31:0] :
                  (r8_px[33] ? 32'sh8000_0000 : 32'sh7fff_ffff);
    assign saty = (r8_py[33:31] == 3'b000 || r8_py[33:31] == 3'b111) ? r8_py[31:0] :
                  (r8_py[33] ? 32'sh8000_0000 : 32'sh7fff_ffff);
    assign nx9  = r8_numpos ? -w_norm.nx : w_norm.nx;
    assign ny9  = r8_numpos ? -w_norm.ny : w_norm.ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov       <= r8_v;
            o_hit      <= hit9;
            o_fraction <= hit9 ? r8_q : '0;
            o_point_x  <= hit9 ? satx : '0;
            o_point_y  <= hit9 ? saty : '0;
            o_normal_x <= hit9 ? nx9 : '0;
            o_normal_y <= hit9 ? ny9 : '0;
        end
    end

    assign o_valid = r_ov;

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_fraction == '0 && o_point_x == '0 && o_point_y == '0 &&
                              o_normal_x == '0 && o_normal_y == '0)
        else $error("miss result not cleared");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> o_fraction <= FRAC_ONE)
        else $error("fraction above one");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_norm.busy |-> o_stall)
        else $error("item taken while normal unit busy");

    a_edge_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        edge_wr |=> w_norm.busy)
        else $error("endpoint write did not start normal unit");
`endif

endmodule
